FILE: rtl/bvt_pkg.sv
// bvt_pkg: sizes, command codes and the per-cell command struct of the
// bounded vector table. Depends on nothing; used by every rtl file.
package bvt_pkg;

  localparam int CAPACITY      = 16;
  localparam int ELEMENT_WIDTH = 32;

  localparam int IN_IDX_W = 5;
  localparam int DATA_W   = 32;
  localparam int OUT_W    = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_INSERT   = 3'd1,
    CMD_GET      = 3'd2,
    CMD_INDEX_OF = 3'd3,
    CMD_REMOVE   = 3'd4,
    CMD_SET      = 3'd5
  } bvt_cmd_t;

  typedef struct packed {
    bvt_cmd_t                 op;
    logic                     exec;
    logic [CMP_W-1:0]         idx;
    logic [CMP_W-1:0]         count;
    logic [ELEMENT_WIDTH-1:0] word;
  } bvt_cell_cmd_t;

endpackage

FILE: rtl/bvt_cell.sv
// bvt_cell: one entry of the list. Loads the command word, takes a
// neighbour's entry on insert or remove, and flags a search hit. Uses bvt_pkg.
module bvt_cell (
  input  logic                                 clk,
  input  bvt_pkg::bvt_cell_cmd_t               cmd,
  input  logic [bvt_pkg::POS_W-1:0]            cell_idx,
  input  logic [bvt_pkg::ELEMENT_WIDTH-1:0]    left_data,
  input  logic [bvt_pkg::ELEMENT_WIDTH-1:0]    right_data,
  output logic [bvt_pkg::ELEMENT_WIDTH-1:0]    data,
  output logic                                 hit
);
  import bvt_pkg::*;

  logic [ELEMENT_WIDTH-1:0] data_r;
  logic [ELEMENT_WIDTH-1:0] data_nxt;
  logic [CMP_W-1:0]         pos_ext;

  always_comb begin
    pos_ext  = CMP_W'(cell_idx);
    data_nxt = data_r;
    if (cmd.exec) begin
      case (cmd.op)
        CMD_APPEND: begin
          if (pos_ext == cmd.count) data_nxt = cmd.word;
        end
        CMD_INSERT: begin
          if (pos_ext == cmd.idx) data_nxt = cmd.word;
          else if (pos_ext > cmd.idx && pos_ext <= cmd.count) data_nxt = left_data;
        end
        CMD_REMOVE: begin
          // shift down the entries above the removed one
          if (pos_ext >= cmd.idx && (pos_ext + CMP_W'(1)) < cmd.count) data_nxt = right_data;
        end
        CMD_SET: begin
          if (pos_ext == cmd.idx) data_nxt = cmd.word;
        end
        default: begin
        end
      endcase
    end
  end

  assign hit  = (pos_ext < cmd.count) && (data_r == cmd.word);
  assign data = data_r;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

FILE: rtl/bvt_first_match.sv
// bvt_first_match: priority encoder giving the lowest set position of the
// registered hit vector. Uses bvt_pkg.
module bvt_first_match (
  input  logic [bvt_pkg::CAPACITY-1:0] hit,
  output logic                         found,
  output logic [bvt_pkg::POS_W-1:0]    pos
);
  import bvt_pkg::*;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    // scan from the top so the lowest hit wins
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        pos   = POS_W'(i);
      end
    end
  end

endmodule

FILE: rtl/bounded_vector_table.sv
// bounded_vector_table: top level, a row of bvt_cell entries with a count,
// a result stage and a first-match output stage. Uses bvt_pkg, bvt_cell and
// bvt_first_match.
//
// Usage: each request on the in_ channel carries a command, an index and a
// value; every request gives exactly one result on the out_ channel with an
// ok flag, the word read by get, the position found by index_of (all ones if
// absent) and the count after the command.
// Pipeline: a result passes the result stage and then the output register before it shows on out_valid.
// Throughput: one request per cycle while in_stall is low. The cell row compares and shifts every
// entry in the cycle of acceptance, and the first-match encoder sits in the
// second register stage, so neither limits the rate.
// Reset: rst_n low clears the count and empties both stages; the entries are
// not cleared, as positions at or above the count are never read.
// Stall: out_stall holds the output register; the result stage keeps filling
// until it too is held, and in_stall rises once both stages are occupied.
// Requests with unused command codes are answered with ok low and nothing
// changes.
module bounded_vector_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_command,
  input  logic [4:0]                  in_index,
  input  logic signed [31:0]          in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_ok,
  output logic signed [31:0]          out_read_value,
  output logic signed [4:0]           out_found_position,
  output logic [4:0]                  out_count
);
  import bvt_pkg::*;

  // list count
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // command decode
  bvt_cmd_t                 op;
  logic                     accept;
  logic                     cmd_ok;
  logic                     full;
  logic [CMP_W-1:0]         idx_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [ELEMENT_WIDTH-1:0] word;
  logic [DATA_W-1:0]        rd_word;
  bvt_cell_cmd_t            cell_cmd;

  // cell row
  logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_hit;

  // result stage
  logic                s1_valid_r;
  logic                s1_ok_r;
  logic                s1_search_r;
  logic [CAPACITY-1:0] s1_hit_r;
  logic [DATA_W-1:0]   s1_rd_r;
  logic [OUT_W-1:0]    s1_count_r;

  // output stage
  logic              out_valid_r;
  logic              out_ok_r;
  logic [DATA_W-1:0] out_rd_r;
  logic [OUT_W-1:0]  out_pos_r;
  logic [OUT_W-1:0]  out_count_r;

  logic             adv_out;
  logic             adv_s1;
  logic             fm_found;
  logic [POS_W-1:0] fm_pos;
  logic [OUT_W-1:0] pos_nxt;

  // Back-pressure: each stage advances when empty or when the next one moves.
  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s1   = !s1_valid_r || adv_out;
  assign in_stall = !adv_s1;
  assign accept   = in_valid && !in_stall;

  assign op      = bvt_cmd_t'(in_command);
  assign idx_ext = CMP_W'(in_index);
  assign cnt_ext = CMP_W'(count_r);
  // cast the value to the entry width; both are 32 bits, so no bits change
  assign word    = ELEMENT_WIDTH'(in_value);
  assign full    = (cnt_ext == CMP_W'(CAPACITY));

  always_comb begin
    cmd_ok    = 1'b0;
    count_nxt = count_r;
    case (op)
      CMD_APPEND: begin
        cmd_ok = !full;
        if (cmd_ok) count_nxt = count_r + CNT_W'(1);
      end
      CMD_INSERT: begin
        cmd_ok = !full && (idx_ext <= cnt_ext);
        if (cmd_ok) count_nxt = count_r + CNT_W'(1);
      end
      CMD_GET: begin
        cmd_ok = (idx_ext < cnt_ext);
      end
      CMD_INDEX_OF: begin
        cmd_ok = 1'b1;
      end
      CMD_REMOVE: begin
        cmd_ok = (idx_ext < cnt_ext);
        if (cmd_ok) count_nxt = count_r - CNT_W'(1);
      end
      CMD_SET: begin
        cmd_ok = (idx_ext < cnt_ext);
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  // Broadcast the request to every cell; only an accepted, valid one acts.
  always_comb begin
    cell_cmd.op    = op;
    cell_cmd.exec  = accept && cmd_ok;
    cell_cmd.idx   = idx_ext;
    cell_cmd.count = cnt_ext;
    cell_cmd.word  = word;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left_w;
    logic [ELEMENT_WIDTH-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = word;
    end else begin : g_mid
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[g];
    end else begin : g_inner
      assign right_w = cell_data[g+1];
    end
    bvt_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .cell_idx   (POS_W'(g)),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[g]),
      .hit        (cell_hit[g])
    );
  end

  // Select the word for get; the index is in range whenever get is accepted.
  always_comb begin
    rd_word = '0;
    if (op == CMD_GET && cmd_ok) rd_word = DATA_W'(cell_data[idx_ext[POS_W-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // Result stage: hold while the output register is stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok_r     <= cmd_ok;
      s1_search_r <= (op == CMD_INDEX_OF);
      s1_hit_r    <= cell_hit;
      s1_rd_r     <= rd_word;
      s1_count_r  <= OUT_W'(count_nxt);
    end
  end

  bvt_first_match u_first_match (
    .hit   (s1_hit_r),
    .found (fm_found),
    .pos   (fm_pos)
  );

  always_comb begin
    pos_nxt = '0;
    if (s1_search_r) pos_nxt = fm_found ? OUT_W'(fm_pos) : '1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_out) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid_r) begin
      out_ok_r    <= s1_ok_r;
      out_rd_r    <= s1_rd_r;
      out_pos_r   <= pos_nxt;
      out_count_r <= s1_count_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_ok_r;
  assign out_read_value     = out_rd_r;
  assign out_found_position = out_pos_r;
  assign out_count          = out_count_r;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= CMP_W'(CAPACITY))
    else $error("count above capacity");

  // A stall on the input only when both stages hold a result.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with a free stage");

  // A rejected request leaves the count untouched.
  a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cmd_ok) |=> $stable(count_r))
    else $error("rejected request changed the count");

  // An accepted append grows the list by one.
  a_append_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd_ok && op == CMD_APPEND) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("append did not grow the list");

  // The result stage holds its result while the output is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv_out) |=> (s1_valid_r && $stable(s1_count_r) && $stable(s1_ok_r)))
    else $error("result stage lost a held result");

endmodule
